@@ rtl/core/fpo_pkg.sv @@
// Shared types, field widths and constants for the focus peaking overlay.
package fpo_pkg;

    // Default sizes of the line store and the row counter
    localparam int MAX_WIDTH_DEF  = 512;
    localparam int MAX_HEIGHT_DEF = 4096;

    // Field and register widths
    localparam int PIX_W      = 8;
    localparam int OUT_COL_W  = 9;
    localparam int OUT_ROW_W  = 12;
    localparam int FW_W       = 10;
    localparam int FH_W       = 13;
    localparam int TH_W       = 9;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_THRESHOLD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PEAKING_ENABLE = 2'd3;

    // Configuration reset values
    localparam logic [FW_W-1:0] FRAME_WIDTH_RST    = 10'd512;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST   = 13'd512;
    localparam logic [TH_W-1:0] EDGE_THRESHOLD_RST = 9'd40;

    // Highlight color
    localparam logic [PIX_W-1:0] HL_RED        = 8'd255;
    localparam logic [PIX_W-1:0] HL_GREEN_BLUE = 8'd40;

    // Input request
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             frame_start;
    } pixel_in_t;

    // Result request
    typedef struct packed {
        logic [OUT_COL_W-1:0] out_col;
        logic [OUT_ROW_W-1:0] out_row;
        logic [PIX_W-1:0]     red;
        logic [PIX_W-1:0]     green;
        logic [PIX_W-1:0]     blue;
        logic                 marked;
        logic                 last_of_run;
    } result_t;

    // One line store entry: the two rows above the incoming pixel
    typedef struct packed {
        logic [PIX_W-1:0] older;
        logic [PIX_W-1:0] prev;
    } line_entry_t;

    // Position flags handed from the counters to the gradient stage
    typedef struct packed {
        logic has_above;
        logic last_row;
        logic right_ok;
        logic border;
    } pos_flags_t;

endpackage

@@ rtl/core/fpo_pos_ctrl.sv @@
// Column and row counters with frame size clamping and position flags.
module fpo_pos_ctrl
    import fpo_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          accept,
    input  logic                          frame_start,
    input  logic [FW_W-1:0]               frame_width,
    input  logic [FH_W-1:0]               frame_height,
    output logic [$clog2(MAX_WIDTH)-1:0]  col,
    output logic [$clog2(MAX_HEIGHT)-1:0] row,
    output pos_flags_t                    flags
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int WCMP = (CW + 1 > FW_W) ? CW + 1 : FW_W;
    localparam int HCMP = (RW + 1 > FH_W) ? RW + 1 : FH_W;

    logic [CW-1:0]   col_reg, col_next;
    logic [RW-1:0]   row_reg, row_next;
    logic [WCMP-1:0] fw_ext;
    logic [HCMP-1:0] fh_ext;
    logic [CW-1:0]   w_last;
    logic [RW-1:0]   h_last;
    logic [CW-1:0]   col_raw;
    logic [RW-1:0]   row_raw;
    logic            col_last;

    // Clamp the configured size to 1..MAX and take the last index
    assign fw_ext = WCMP'(frame_width);
    assign fh_ext = HCMP'(frame_height);

    always_comb begin
        if (fw_ext == '0) begin
            w_last = '0;
        end else if (fw_ext > WCMP'(MAX_WIDTH)) begin
            w_last = CW'(MAX_WIDTH - 1);
        end else begin
            w_last = CW'(fw_ext - 1'b1);
        end
        if (fh_ext == '0) begin
            h_last = '0;
        end else if (fh_ext > HCMP'(MAX_HEIGHT)) begin
            h_last = RW'(MAX_HEIGHT - 1);
        end else begin
            h_last = RW'(fh_ext - 1'b1);
        end
    end

    // Restart on frame start, saturate counters past a shrunk size
    assign col_raw = frame_start ? '0 : col_reg;
    assign row_raw = frame_start ? '0 : row_reg;
    assign col     = (col_raw > w_last) ? w_last : col_raw;
    assign row     = (row_raw > h_last) ? h_last : row_raw;

    assign col_last        = (col == w_last);
    assign flags.has_above = (row != '0);
    assign flags.last_row  = (row == h_last);
    assign flags.right_ok  = !col_last;
    assign flags.border    = (col == '0) || col_last || (row == RW'(1));

    // Advance in raster order, wrap at the end of a row and of the frame
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (col_last) begin
                col_next = '0;
                row_next = flags.last_row ? '0 : RW'(row + 1'b1);
            end else begin
                col_next = CW'(col + 1'b1);
                row_next = row;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

@@ rtl/core/fpo_line_store.sv @@
// Two-row line store memory with registered reads and write forwarding.
module fpo_line_store
    import fpo_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
    input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr_right,
    input  logic                         wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
    input  line_entry_t                  wr_data,
    output line_entry_t                  rd_data,
    output logic [PIX_W-1:0]             rd_right
);

    line_entry_t      mem [MAX_WIDTH];
    line_entry_t      rd_data_reg;
    logic [PIX_W-1:0] rd_right_reg;

    // Write back the updated column
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read the column and its right neighbor; forward a same-cycle write
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (wr_en && (wr_addr == rd_addr)) begin
                rd_data_reg <= wr_data;
            end else begin
                rd_data_reg <= mem[rd_addr];
            end
            if (wr_en && (wr_addr == rd_addr_right)) begin
                rd_right_reg <= wr_data.prev;
            end else begin
                rd_right_reg <= mem[rd_addr_right].prev;
            end
        end
    end

    assign rd_data  = rd_data_reg;
    assign rd_right = rd_right_reg;

endmodule

@@ rtl/core/fpo_grad_out.sv @@
// Gradient test, result sequencing, write-back and the output register.
module fpo_grad_out
    import fpo_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          accept,
    input  logic [PIX_W-1:0]              in_px,
    input  logic [$clog2(MAX_WIDTH)-1:0]  in_col,
    input  logic [$clog2(MAX_HEIGHT)-1:0] in_row,
    input  pos_flags_t                    in_flags,
    input  line_entry_t                   rd_data,
    input  logic [PIX_W-1:0]              rd_right,
    input  logic [TH_W-1:0]               edge_threshold,
    input  logic                          peaking_enable,
    output logic                          s_ready,
    output logic                          wr_en,
    output logic [$clog2(MAX_WIDTH)-1:0]  wr_addr,
    output line_entry_t                   wr_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output result_t                       m_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic             b_valid_reg, b_valid_next;
    logic             phase_reg, phase_next;
    logic [PIX_W-1:0] px_reg;
    logic [CW-1:0]    col_reg;
    logic [RW-1:0]    row_reg;
    pos_flags_t       flags_reg;
    logic [PIX_W-1:0] left_reg;
    logic             m_valid_reg, m_valid_next;
    result_t          m_data_reg;

    logic [PIX_W-1:0] centre, above, right;
    logic [PIX_W-1:0] d_lr, d_ba;
    logic [TH_W-1:0]  grad;
    logic             mark;
    logic             first_due, has_any, final_res;
    logic             out_free, emit, b_done;
    result_t          res;

    // Neighborhood of the pixel one row above the input
    assign centre = rd_data.prev;
    assign above  = rd_data.older;
    assign right  = flags_reg.right_ok ? rd_right : '0;

    // Cross-shaped central difference
    assign d_lr = (right > left_reg) ? right - left_reg : left_reg - right;
    assign d_ba = (px_reg > above) ? px_reg - above : above - px_reg;
    assign grad = TH_W'({1'b0, d_lr}) + TH_W'({1'b0, d_ba});
    assign mark = peaking_enable && !flags_reg.border && (grad > edge_threshold);

    // Pick the result for this cycle: row above first, then the last row
    assign first_due = flags_reg.has_above && !phase_reg;
    assign has_any   = flags_reg.has_above || flags_reg.last_row;
    assign final_res = first_due ? !flags_reg.last_row : 1'b1;

    always_comb begin
        if (first_due) begin
            res.out_col     = OUT_COL_W'(col_reg);
            res.out_row     = OUT_ROW_W'(RW'(row_reg - 1'b1));
            res.red         = mark ? HL_RED : centre;
            res.green       = mark ? HL_GREEN_BLUE : centre;
            res.blue        = mark ? HL_GREEN_BLUE : centre;
            res.marked      = mark;
            res.last_of_run = !flags_reg.last_row;
        end else begin
            res.out_col     = OUT_COL_W'(col_reg);
            res.out_row     = OUT_ROW_W'(row_reg);
            res.red         = px_reg;
            res.green       = px_reg;
            res.blue        = px_reg;
            res.marked      = 1'b0;
            res.last_of_run = 1'b1;
        end
    end

    // Handshake between the stage and the output register
    assign out_free = !m_valid_reg || m_ready;
    assign emit     = b_valid_reg && has_any && out_free;
    assign b_done   = b_valid_reg && (!has_any || (emit && final_res));
    assign s_ready  = !b_valid_reg || b_done;

    // Write back the column once its last result is out, or when it has none
    assign wr_en   = b_done;
    assign wr_addr = col_reg;
    assign wr_data = '{older: centre, prev: px_reg};

    always_comb begin
        b_valid_next = b_valid_reg;
        phase_next   = phase_reg;
        m_valid_next = m_valid_reg;
        if (b_done) begin
            b_valid_next = 1'b0;
            phase_next   = 1'b0;
        end else if (emit) begin
            phase_next = 1'b1;
        end
        if (accept) begin
            b_valid_next = 1'b1;
        end
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            phase_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
            left_reg    <= '0;
        end else begin
            b_valid_reg <= b_valid_next;
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
            if (b_done) begin
                left_reg <= centre;
            end
        end
    end

    // Capture the accepted request and load results
    always_ff @(posedge aclk) begin
        if (accept) begin
            px_reg    <= in_px;
            col_reg   <= in_col;
            row_reg   <= in_row;
            flags_reg <= in_flags;
        end
        if (emit) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The second result only follows a first one on the last row
    assert property (@(posedge aclk) disable iff (!aresetn)
        b_valid_reg && phase_reg |-> flags_reg.last_row && flags_reg.has_above)
        else $error("second result phase outside the last row");

    // A non-final result keeps the stage busy for the second one
    assert property (@(posedge aclk) disable iff (!aresetn)
        emit && !final_res |=> b_valid_reg && phase_reg)
        else $error("stage dropped its second result");

    // A finished stage with no new request goes empty
    assert property (@(posedge aclk) disable iff (!aresetn)
        b_done && !accept |=> !b_valid_reg)
        else $error("stage held after completion");

    // Highlighted pixels never sit in column zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.marked |-> m_data_reg.out_col != '0)
        else $error("border pixel highlighted");

endmodule

@@ rtl/core/focus_peaking_overlay_unit.sv @@
// Top level of the focus peaking overlay: configuration registers and wiring.
//
// Takes one grey pixel per clock in raster order, unless stalled, and returns
// RGB pixels one row behind, highlighting edges in red. A request is read from
// the line store at acceptance, then judged and placed in the output register.
// Inputs that cause at most one result go through at one per clock while the
// output is not held; on the last row of a frame taller than one row each input
// causes two results, which share the single output register, so that row takes
// a new pixel only as its second result leaves. The line store is one memory of
// MAX_WIDTH entries with two read ports and one write port.
module focus_peaking_overlay_unit
    import fpo_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  pixel_in_t             s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output result_t               m_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic [FW_W-1:0]  frame_width_reg;
    logic [FH_W-1:0]  frame_height_reg;
    logic [TH_W-1:0]  edge_threshold_reg;
    logic             peaking_enable_reg;

    logic             accept;
    logic [CW-1:0]    col;
    logic [RW-1:0]    row;
    pos_flags_t       flags;
    logic             wr_en;
    logic [CW-1:0]    wr_addr;
    line_entry_t      wr_data;
    line_entry_t      rd_data;
    logic [PIX_W-1:0] rd_right;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg    <= FRAME_WIDTH_RST;
            frame_height_reg   <= FRAME_HEIGHT_RST;
            edge_threshold_reg <= EDGE_THRESHOLD_RST;
            peaking_enable_reg <= 1'b1;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_FRAME_WIDTH:    frame_width_reg    <= cfg_wdata[FW_W-1:0];
                REG_FRAME_HEIGHT:   frame_height_reg   <= cfg_wdata[FH_W-1:0];
                REG_EDGE_THRESHOLD: edge_threshold_reg <= cfg_wdata[TH_W-1:0];
                REG_PEAKING_ENABLE: peaking_enable_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign accept = s_valid && s_ready;

    fpo_pos_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_pos (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .frame_start  (s_data.frame_start),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .col          (col),
        .row          (row),
        .flags        (flags)
    );

    fpo_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_store (
        .aclk          (aclk),
        .rd_en         (accept),
        .rd_addr       (col),
        .rd_addr_right (CW'(col + 1'b1)),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .rd_data       (rd_data),
        .rd_right      (rd_right)
    );

    fpo_grad_out #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_grad (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .accept         (accept),
        .in_px          (s_data.pixel),
        .in_col         (col),
        .in_row         (row),
        .in_flags       (flags),
        .rd_data        (rd_data),
        .rd_right       (rd_right),
        .edge_threshold (edge_threshold_reg),
        .peaking_enable (peaking_enable_reg),
        .s_ready        (s_ready),
        .wr_en          (wr_en),
        .wr_addr        (wr_addr),
        .wr_data        (wr_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data)
    );

endmodule
